### src/hfbf_pkg.sv
package hfbf_pkg;

	localparam int SlotW  = 12;
	localparam int WordW  = 64;
	localparam int PtrW   = 6;
	localparam int Words  = 64;
	localparam int CountW = 13;

	localparam logic [CountW-1:0] COUNT_RESET = 13'd4096;
	localparam logic [WordW-1:0]  WORD_FULL   = {WordW{1'b1}};

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_FIND  = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [SlotW-1:0] bit_index;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [SlotW-1:0] found_index;
	} out_item_t;

	typedef struct packed {
		logic             rd_en;
		logic [PtrW-1:0]  rd_addr;
		logic             wr_en;
		logic [PtrW-1:0]  wr_addr;
		logic [WordW-1:0] wr_data;
	} leaf_req_t;

	// lowest zero bit; result is don't-care for an all-ones word
	function automatic logic [PtrW-1:0] first_zero(input logic [WordW-1:0] w);
		logic [PtrW-1:0] r;
		r = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (!w[i]) r = PtrW'(i);
		end
		return r;
	endfunction

endpackage

### src/hfbf_leaf_store.sv
module hfbf_leaf_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hfbf_pkg::leaf_req_t       req,
	output logic [hfbf_pkg::WordW-1:0] rd_word
);

	logic [hfbf_pkg::WordW-1:0] mem [hfbf_pkg::Words];
	logic [hfbf_pkg::WordW-1:0] rd_data_s1;
	logic                       rd_vld_s1;
	logic [hfbf_pkg::Words-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) rd_data_s1 <= mem[req.rd_addr];
	end

	// a word never written since reset reads as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) vld_q[req.wr_addr] <= 1'b1;
			if (req.rd_en) rd_vld_s1 <= vld_q[req.rd_addr];
		end
	end

	assign rd_word = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

### src/hierarchical_free_bit_finder.sv
// Two-level 64-ary free-slot bitmap over 4096 slots, all clear after reset.
// Every operation (set, clear, find) reads a leaf word from the 64 x 64 leaf
// RAM in the transfer cycle (for a find, the word picked by the first zero of
// the summary register); in the execute state, once the output register is
// free, a set or clear writes the modified word back and updates the summary
// bit, and the result is loaded into the output register. The single leaf RAM
// is read then written, so a new item is accepted only after the last one has
// executed. The leaf RAM needs no clearing pass after reset; each word has a
// valid bit. bit_count lies at byte address 0 of the APB port.
module hierarchical_free_bit_finder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  hfbf_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hfbf_pkg::out_item_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic       ST_IDLE = 1'b0;
	localparam logic       ST_EXEC = 1'b1;
	localparam logic [2:0] ADDR_BIT_COUNT = 3'd0;

	logic                                 state_q;
	logic [hfbf_pkg::CountW-1:0]          bit_count_q;
	logic [hfbf_pkg::WordW-1:0]           summary_q;
	logic                                 out_valid_q;
	hfbf_pkg::out_item_t                  out_q;

	logic [1:0]                           mode_s1;
	logic [hfbf_pkg::SlotW-1:0]           idx_s1;
	logic [hfbf_pkg::PtrW-1:0]            ptr_s1;
	logic                                 sum_full_s1;

	hfbf_pkg::leaf_req_t                  leaf_req;
	logic [hfbf_pkg::WordW-1:0]           leaf;
	logic [hfbf_pkg::WordW-1:0]           bit_mask;
	logic [hfbf_pkg::WordW-1:0]           set_word;
	logic [hfbf_pkg::WordW-1:0]           clr_word;
	logic [hfbf_pkg::SlotW-1:0]           slot;
	logic                                 hit;
	logic                                 in_fire;
	logic                                 exec_fire;
	logic                                 cfg_wr;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BIT_COUNT);
	assign prdata = (paddr == ADDR_BIT_COUNT) ?
		{{(32 - hfbf_pkg::CountW){1'b0}}, bit_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= hfbf_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			bit_count_q <= pwdata[hfbf_pkg::CountW-1:0];
		end
	end

	// leaf RAM access: read on transfer, write back on execute of a set or clear
	always_comb begin
		leaf_req.rd_en   = in_fire;
		leaf_req.rd_addr = (in_data.mode == hfbf_pkg::MODE_FIND) ?
			hfbf_pkg::first_zero(summary_q) :
			in_data.bit_index[hfbf_pkg::SlotW-1 -: hfbf_pkg::PtrW];
		leaf_req.wr_en   = exec_fire &&
			(mode_s1 == hfbf_pkg::MODE_SET || mode_s1 == hfbf_pkg::MODE_CLEAR);
		leaf_req.wr_addr = ptr_s1;
		leaf_req.wr_data = (mode_s1 == hfbf_pkg::MODE_SET) ? set_word : clr_word;
	end

	hfbf_leaf_store u_leaf_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (leaf_req),
		.rd_word (leaf)
	);

	assign bit_mask = {{(hfbf_pkg::WordW - 1){1'b0}}, 1'b1} << idx_s1[hfbf_pkg::PtrW-1:0];
	assign set_word = leaf | bit_mask;
	assign clr_word = leaf & ~bit_mask;
	assign slot     = {ptr_s1, hfbf_pkg::first_zero(leaf)};
	assign hit      = (mode_s1 == hfbf_pkg::MODE_FIND) && !sum_full_s1 &&
		(leaf != hfbf_pkg::WORD_FULL) && ({1'b0, slot} < bit_count_q);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1     <= in_data.mode;
			idx_s1      <= in_data.bit_index;
			ptr_s1      <= leaf_req.rd_addr;
			sum_full_s1 <= (summary_q == hfbf_pkg::WORD_FULL);
		end
		if (exec_fire) begin
			out_q.found       <= hit;
			out_q.found_index <= hit ? slot : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			summary_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_EXEC;
				ST_EXEC: if (exec_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (exec_fire) begin
				if (mode_s1 == hfbf_pkg::MODE_SET && set_word == hfbf_pkg::WORD_FULL)
					summary_q[ptr_s1] <= 1'b1;
				else if (mode_s1 == hfbf_pkg::MODE_CLEAR)
					summary_q[ptr_s1] <= 1'b0;
			end
			if (exec_fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_EXEC)
		else $error("transfer did not start execute");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid)
		else $error("execute did not produce a result");

	a_nonfind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && mode_s1 != hfbf_pkg::MODE_FIND |=>
			!out_data.found && out_data.found_index == '0)
		else $error("set or clear reported a slot");

	a_full_summary: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && mode_s1 == hfbf_pkg::MODE_SET && set_word == hfbf_pkg::WORD_FULL
			|=> summary_q[$past(ptr_s1)])
		else $error("full leaf word not marked in summary");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(leaf_req.rd_en && leaf_req.wr_en))
		else $error("leaf RAM read and write in the same cycle");

endmodule
